@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros sampled on clk, ASSERT_CLK disabled during active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

@@ design/kefr_pkg.sv @@
// ----------------------------------------------------------------------------
// kefr_pkg
// types and constants for the key event fifo with typematic repeat
// ----------------------------------------------------------------------------
package kefr_pkg;

    // event ring depth, one slot always left empty
    localparam int FIFO_DEPTH = 128;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam int EVENT_W = 32;
    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;

    // reset values of the configuration registers
    localparam logic [MS_W-1:0]    RESET_DELAY_MS    = MS_W'(500);
    localparam logic [MS_W-1:0]    RESET_INTERVAL_MS = MS_W'(50);
    localparam logic [EVENT_W-1:0] RESET_KEY_CODE    = EVENT_W'(8);

    // event word layout
    localparam int RELEASE_BIT = 31;
    localparam logic [EVENT_W-1:0] SPECIAL_MASK = 32'hFF00_0000;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_POLL = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY    = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_KEY      = 2'd2
    } cfg_idx_t;

    // ring successor of a slot index
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(FIFO_DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

@@ design/key_event_fifo_with_repeat_top.sv @@
// A result strobes on done in the cycle after its command transfer.
// Throughput: one command per cycle; busy stays low, since each command is a
// single write or a single read of the event ring memory plus pointer updates at most.
// Pop data comes from the registered read port of the ring memory.
// Reset: rst_n clears pointers, key tracking and config to defaults at once;
// ring contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// key_event_fifo_with_repeat_top
// key event ring fifo with press/release tracking and typematic repeat
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_event_fifo_with_repeat_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic [kefr_pkg::EVENT_W-1:0]        event_word,
    input  logic [kefr_pkg::TIME_W-1:0]         now_ms,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [kefr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kefr_pkg::EVENT_W-1:0]        cfg_data,
    // result channel
    output logic                                done,
    output logic [kefr_pkg::EVENT_W-1:0]        popped_event,
    output logic                                popped_valid,
    output logic [kefr_pkg::CHAR_W-1:0]         char_code,
    output logic                                events_waiting,
    output logic                                push_accepted
);

    localparam int PTR_W = kefr_pkg::PTR_W;

    // configuration registers
    logic [kefr_pkg::MS_W-1:0]    delay_ms_reg;
    logic [kefr_pkg::MS_W-1:0]    interval_ms_reg;
    logic [kefr_pkg::EVENT_W-1:0] key_code_reg;

    // ring and key tracking state
    logic [PTR_W-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [kefr_pkg::EVENT_W-1:0]  held_key_reg, held_key_next;
    logic [kefr_pkg::TIME_W-1:0]   press_time_reg, press_time_next;
    logic [kefr_pkg::TIME_W-1:0]   last_rep_reg, last_rep_next;
    logic                          key_held_reg, key_held_next;

    // result registers
    logic                          done_reg;
    logic                          pop_valid_reg, pop_valid_next;
    logic                          push_acc_reg, push_acc_next;
    logic                          waiting_reg;
    logic [kefr_pkg::EVENT_W-1:0]  rd_data_reg;

    // ring memory
    logic [kefr_pkg::EVENT_W-1:0]  mem [kefr_pkg::FIFO_DEPTH];
    logic                          mem_we;
    logic                          mem_re;
    logic [kefr_pkg::EVENT_W-1:0]  mem_wdata;

    logic                          accept;
    kefr_pkg::op_t                 op;
    logic                          fifo_full;
    logic                          fifo_empty;
    logic [kefr_pkg::TIME_W-1:0]   since_press;
    logic [kefr_pkg::TIME_W-1:0]   since_repeat;
    logic                          repeat_due;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = kefr_pkg::op_t'(opcode);

    assign fifo_full  = (kefr_pkg::next_slot(wr_ptr_reg) == rd_ptr_reg);
    assign fifo_empty = (rd_ptr_reg == wr_ptr_reg);

    // repeat timing, differences wrap modulo 2^32
    assign since_press  = now_ms - press_time_reg;
    assign since_repeat = now_ms - last_rep_reg;
    assign repeat_due   = key_held_reg && (held_key_reg == key_code_reg)
                       && (since_press  > {16'd0, delay_ms_reg})
                       && (since_repeat > {16'd0, interval_ms_reg});

    // command decode and next state
    always_comb
    begin
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        held_key_next   = held_key_reg;
        press_time_next = press_time_reg;
        last_rep_next   = last_rep_reg;
        key_held_next   = key_held_reg;
        pop_valid_next  = 1'b0;
        push_acc_next   = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = event_word;
        if (accept)
        begin
            unique case (op)
                kefr_pkg::OP_PUSH:
                begin
                    if (event_word[kefr_pkg::RELEASE_BIT])
                    begin
                        if (event_word[7:0] == held_key_reg[7:0])
                        begin
                            key_held_next = 1'b0;
                        end
                    end
                    else
                    begin
                        held_key_next   = event_word;
                        press_time_next = now_ms;
                        last_rep_next   = now_ms;
                        key_held_next   = 1'b1;
                    end
                    if (!fifo_full)
                    begin
                        mem_we        = 1'b1;
                        wr_ptr_next   = kefr_pkg::next_slot(wr_ptr_reg);
                        push_acc_next = 1'b1;
                    end
                end
                kefr_pkg::OP_POP:
                begin
                    if (!fifo_empty)
                    begin
                        mem_re         = 1'b1;
                        rd_ptr_next    = kefr_pkg::next_slot(rd_ptr_reg);
                        pop_valid_next = 1'b1;
                    end
                end
                kefr_pkg::OP_POLL:
                begin
                    if (repeat_due)
                    begin
                        last_rep_next = now_ms;
                        mem_wdata     = key_code_reg;
                        if (!fifo_full)
                        begin
                            mem_we        = 1'b1;
                            wr_ptr_next   = kefr_pkg::next_slot(wr_ptr_reg);
                            push_acc_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ms_reg    <= kefr_pkg::RESET_DELAY_MS;
            interval_ms_reg <= kefr_pkg::RESET_INTERVAL_MS;
            key_code_reg    <= kefr_pkg::RESET_KEY_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kefr_pkg::CFG_DELAY:    delay_ms_reg    <= cfg_data[kefr_pkg::MS_W-1:0];
                kefr_pkg::CFG_INTERVAL: interval_ms_reg <= cfg_data[kefr_pkg::MS_W-1:0];
                kefr_pkg::CFG_KEY:      key_code_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // control state and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            held_key_reg   <= '0;
            press_time_reg <= '0;
            last_rep_reg   <= '0;
            key_held_reg   <= 1'b0;
            done_reg       <= 1'b0;
            pop_valid_reg  <= 1'b0;
            push_acc_reg   <= 1'b0;
            waiting_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            held_key_reg   <= held_key_next;
            press_time_reg <= press_time_next;
            last_rep_reg   <= last_rep_next;
            key_held_reg   <= key_held_next;
            done_reg       <= accept;
            pop_valid_reg  <= pop_valid_next;
            push_acc_reg   <= push_acc_next;
            waiting_reg    <= (rd_ptr_next != wr_ptr_next);
        end
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // result outputs
    assign done           = done_reg;
    assign popped_valid   = pop_valid_reg;
    assign popped_event   = pop_valid_reg ? rd_data_reg : '0;
    assign char_code      = (pop_valid_reg && ((rd_data_reg & kefr_pkg::SPECIAL_MASK) == '0))
                          ? rd_data_reg[kefr_pkg::CHAR_W-1:0] : '0;
    assign events_waiting = waiting_reg;
    assign push_accepted  = push_acc_reg;

    // checks
    `ASSERT_CLK(a_done_follows_start, start |=> done_reg,
        "command transfer not followed by a result strobe")
    `ASSERT_CLK(a_done_has_cause, done_reg |-> $past(accept),
        "result strobe without a command transfer")
    `ASSERT_CLK(a_pop_needs_data, pop_valid_reg |-> $past(rd_ptr_reg != wr_ptr_reg),
        "pop returned data from an empty ring")
    `ASSERT_CLK(a_push_keeps_gap, push_acc_reg |-> (wr_ptr_reg != rd_ptr_reg),
        "stored event filled the reserved empty slot")
    `ASSERT_ALWAYS(a_flags_exclusive, !(pop_valid_reg && push_acc_reg),
        "pop and store reported for one command")

endmodule
